/* rtl/core/htc_pkg.sv */
package htc_pkg;

	// field widths
	localparam int TEMP_W   = 10;
	localparam int SP_W     = 9;
	localparam int DUTY_W   = 16;
	localparam int BRIGHT_W = 3;
	localparam int ACC_W    = 16;
	localparam int ERR_W    = 11;
	localparam int KP_W     = 20;
	localparam int GAIN_W   = 16;
	localparam int BAND_W   = 8;
	localparam int CFG_W    = 20;
	localparam int CFG_IDX_W = 3;

	// special values
	localparam logic [TEMP_W-1:0]   TEMP_FAULT = 10'd999;
	localparam logic [ACC_W-1:0]    ACC_EMPTY  = 16'hFFFF;
	localparam logic [DUTY_W-1:0]   DUTY_MAX   = 16'hFFFF;
	localparam logic [BRIGHT_W-1:0] BRIGHT_LOW  = 3'd2;
	localparam logic [BRIGHT_W-1:0] BRIGHT_HIGH = 3'd7;

	// approach direction codes
	localparam logic [1:0] DIR_SETTLED = 2'd0;
	localparam logic [1:0] DIR_RISING  = 2'd1;
	localparam logic [1:0] DIR_FALLING = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COOL     = 3'd5;

	// register reset values
	localparam logic [KP_W-1:0]   KP_RESET      = 20'd33204;
	localparam logic [GAIN_W-1:0] KI_RESET      = 16'd262;
	localparam logic [GAIN_W-1:0] KD_RESET      = 16'd20480;
	localparam logic [DUTY_W-1:0] OUT_MAX_RESET = 16'd2048;
	localparam logic [BAND_W-1:0] NEAR_RESET    = 8'd10;
	localparam logic [DUTY_W-1:0] COOL_RESET    = 16'd5;

	typedef struct packed {
		logic [TEMP_W-1:0] measured_temp;
		logic [SP_W-1:0]   setpoint;
	} htc_in_t;

	typedef struct packed {
		logic [DUTY_W-1:0]   heater_duty;
		logic [TEMP_W-1:0]   filtered_temp;
		logic [BRIGHT_W-1:0] display_brightness;
	} htc_out_t;

endpackage

/* rtl/core/heater_temperature_controller.sv */
// channel   direction  handshake                   payload
// sample    in         sample_valid / sample_stall htc_in_t  (temperature, setpoint)
// result    out        result_valid / result_stall htc_out_t (duty, filtered temp, level)
// cfg       in         cfg_wr_en                   cfg_index, cfg_wdata
//
// inside the band, on fault or with the heater off a tick runs the transfer, filter,
// decision and load; when the PD law runs, the four products go one after another
// through a single 29x12 multiplier between the decision and the clamp and load.
// sample_stall is high from the transfer until the result is loaded into the
// output register; a result waiting under result_stall holds the block there.
// arst_n clears sequencer, filter, duty, direction and valid state and restores the register defaults.
module heater_temperature_controller
	import htc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  htc_in_t              sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output htc_out_t             result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_FILT   = 4'd1;
	localparam logic [3:0] ST_DEC    = 4'd2;
	localparam logic [3:0] ST_MUL_KS = 4'd3;
	localparam logic [3:0] ST_MUL_P  = 4'd4;
	localparam logic [3:0] ST_MUL_I  = 4'd5;
	localparam logic [3:0] ST_MUL_D  = 4'd6;
	localparam logic [3:0] ST_CLAMP  = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	localparam int KS_W   = KP_W + SP_W;
	localparam int MB_W   = ERR_W + 1;
	localparam int PROD_W = KS_W + 1 + MB_W;
	localparam int SUM_W  = PROD_W + 2;

	logic [3:0] state_q;

	// configuration
	logic [KP_W-1:0]   kp_q;
	logic [GAIN_W-1:0] ki_q;
	logic [GAIN_W-1:0] kd_q;
	logic [DUTY_W-1:0] out_max_q;
	logic [BAND_W-1:0] near_band_q;
	logic [DUTY_W-1:0] cool_duty_q;

	// controller state
	logic [TEMP_W-1:0]   temp_q;
	logic [SP_W-1:0]     sp_q;
	logic [ACC_W-1:0]    avg_acc_q;
	logic [TEMP_W-1:0]   cur_temp_q;
	logic [DUTY_W-1:0]   duty_q;
	logic [DUTY_W-1:0]   stable_duty_q;
	logic [1:0]          dir_q;
	logic [ERR_W-1:0]    prev_err_q;
	logic [BRIGHT_W-1:0] bright_q;
	logic                falling_q;

	// PD law datapath
	logic [ERR_W-1:0]        err_q;
	logic signed [MB_W-1:0]  diff_q;
	logic [KS_W-1:0]         ks_q;
	logic signed [SUM_W-1:0] pd_sum_q;

	htc_out_t result_q;
	logic     result_valid_q;

	// handshake
	logic sample_xfer;
	logic load_out;

	assign sample_stall = (state_q != ST_IDLE);
	assign sample_xfer  = sample_valid && !sample_stall;
	assign load_out     = (state_q == ST_DONE) && (!result_valid_q || !result_stall);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= KP_RESET;
			ki_q        <= KI_RESET;
			kd_q        <= KD_RESET;
			out_max_q   <= OUT_MAX_RESET;
			near_band_q <= NEAR_RESET;
			cool_duty_q <= COOL_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_KP:      kp_q        <= cfg_wdata[KP_W-1:0];
				REG_KI:      ki_q        <= cfg_wdata[GAIN_W-1:0];
				REG_KD:      kd_q        <= cfg_wdata[GAIN_W-1:0];
				REG_OUT_MAX: out_max_q   <= cfg_wdata[DUTY_W-1:0];
				REG_NEAR:    near_band_q <= cfg_wdata[BAND_W-1:0];
				REG_COOL:    cool_duty_q <= cfg_wdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	// filter step: clamp sample, refill or weighted update
	logic [TEMP_W-1:0]   samp_w;
	logic [ACC_W-1:0]    acc_m8_w;
	logic [ACC_W-1:0]    dec_w;
	logic [ACC_W-1:0]    acc_upd_w;
	logic [BRIGHT_W-1:0] bright_next_w;

	always_comb begin
		samp_w    = (temp_q > TEMP_FAULT) ? TEMP_FAULT : temp_q;
		acc_m8_w  = avg_acc_q - ACC_W'(8);
		// below 8 the decrement is minus one, which adds one mod 2^16
		dec_w     = (avg_acc_q < ACC_W'(8)) ? ACC_EMPTY : {4'd0, acc_m8_w[ACC_W-1:4]};
		acc_upd_w = avg_acc_q + {6'd0, samp_w} - dec_w;
		bright_next_w = falling_q ? (bright_q - BRIGHT_W'(1)) : (bright_q + BRIGHT_W'(1));
	end

	// decision step
	logic signed [ERR_W-1:0] err_w;
	logic signed [ERR_W-1:0] band_w;
	logic                    far_w;
	logic                    off_w;

	always_comb begin
		err_w  = $signed({2'd0, sp_q}) - $signed({1'b0, cur_temp_q});
		band_w = $signed({3'd0, near_band_q});
		far_w  = (err_w > band_w) || (err_w < -band_w);
		off_w  = (sp_q == '0) || (cur_temp_q == TEMP_FAULT);
	end

	// shared multiplier, unsigned 29 bits by signed 12 bits
	logic [KS_W-1:0]          mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod_w;
	logic signed [SUM_W-1:0]  prod_ext_w;

	always_comb begin
		case (state_q)
			ST_MUL_KS: begin
				mul_a = {{(KS_W-KP_W){1'b0}}, kp_q};
				mul_b = $signed({{(MB_W-SP_W){1'b0}}, sp_q});
			end
			ST_MUL_P: begin
				mul_a = ks_q;
				mul_b = $signed({err_q[ERR_W-1], err_q});
			end
			ST_MUL_I: begin
				mul_a = {{(KS_W-GAIN_W){1'b0}}, ki_q};
				mul_b = $signed({err_q[ERR_W-1], err_q});
			end
			ST_MUL_D: begin
				mul_a = {{(KS_W-GAIN_W){1'b0}}, kd_q};
				mul_b = diff_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_w     = $signed({1'b0, mul_a}) * mul_b;
		prod_ext_w = {{(SUM_W-PROD_W){prod_w[PROD_W-1]}}, prod_w};
	end

	// clamp of the PD sum
	logic [SUM_W-21:0] pd_int_w;
	assign pd_int_w = pd_sum_q[SUM_W-1:20];

	// sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			avg_acc_q     <= ACC_EMPTY;
			cur_temp_q    <= '0;
			duty_q        <= '0;
			stable_duty_q <= '0;
			dir_q         <= DIR_SETTLED;
			prev_err_q    <= '0;
			bright_q      <= BRIGHT_HIGH;
			falling_q     <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sample_xfer) begin
						state_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					bright_q <= bright_next_w;
					if (bright_next_w == BRIGHT_LOW || bright_next_w == BRIGHT_HIGH) begin
						falling_q <= !falling_q;
					end
					if (samp_w == TEMP_FAULT) begin
						avg_acc_q  <= ACC_EMPTY;
						cur_temp_q <= TEMP_FAULT;
					end else if (avg_acc_q == ACC_EMPTY) begin
						avg_acc_q  <= {2'd0, samp_w, 4'd0};
						cur_temp_q <= samp_w;
					end else begin
						avg_acc_q  <= acc_upd_w;
						cur_temp_q <= acc_upd_w[TEMP_W+3:4];
					end
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					state_q <= (!off_w && far_w) ? ST_MUL_KS : ST_DONE;
					if (off_w) begin
						duty_q <= '0;
					end else if (far_w) begin
						// PD law, direction of approach recorded now
						err_q      <= err_w;
						diff_q     <= $signed({err_w[ERR_W-1], err_w})
							- $signed({prev_err_q[ERR_W-1], prev_err_q});
						prev_err_q <= err_w;
						dir_q      <= (err_w > 0) ? DIR_RISING : DIR_FALLING;
					end else if (cur_temp_q == {1'b0, sp_q}) begin
						// setpoint reached: latch the duty that got here rising
						if (dir_q == DIR_RISING) begin
							stable_duty_q <= duty_q;
						end
						dir_q <= DIR_SETTLED;
					end else if (cur_temp_q > {1'b0, sp_q}) begin
						duty_q <= cool_duty_q;
						dir_q  <= DIR_FALLING;
					end else begin
						// below setpoint: restart from stable duty or nudge up
						if (dir_q != DIR_RISING) begin
							dir_q  <= DIR_RISING;
							duty_q <= stable_duty_q;
						end else if (duty_q != DUTY_MAX) begin
							duty_q <= duty_q + DUTY_W'(1);
						end
					end
				end
				ST_MUL_KS: begin
					state_q <= ST_MUL_P;
				end
				ST_MUL_P: begin
					state_q <= ST_MUL_I;
				end
				ST_MUL_I: begin
					state_q <= ST_MUL_D;
				end
				ST_MUL_D: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if (pd_sum_q <= 0) begin
						duty_q <= '0;
					end else if (pd_int_w > {{(SUM_W-20-DUTY_W){1'b0}}, out_max_q}) begin
						duty_q <= out_max_q;
					end else begin
						duty_q <= pd_int_w[DUTY_W-1:0];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample capture and PD products
	always_ff @(posedge clk) begin
		if (sample_xfer) begin
			temp_q <= sample.measured_temp;
			sp_q   <= sample.setpoint;
		end
		case (state_q)
			ST_MUL_KS: ks_q     <= prod_w[KS_W-1:0];
			ST_MUL_P:  pd_sum_q <= prod_ext_w;
			ST_MUL_I:  pd_sum_q <= pd_sum_q + (prod_ext_w <<< 4);
			ST_MUL_D:  pd_sum_q <= pd_sum_q + (prod_ext_w <<< 12);
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.heater_duty        <= duty_q;
			result_q.filtered_temp      <= cur_temp_q;
			result_q.display_brightness <= bright_q;
		end
	end

	// checks
	a_xfer_starts_filter: assert property (@(posedge clk) disable iff (!arst_n)
		sample_xfer |=> state_q == ST_FILT)
		else $error("sample transfer did not start the filter step");

	a_fault_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.filtered_temp == TEMP_FAULT |-> result.heater_duty == '0)
		else $error("nonzero duty reported on fault");

	a_bright_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.display_brightness >= BRIGHT_LOW
			&& result.display_brightness <= BRIGHT_HIGH)
		else $error("brightness out of range");

	a_clamp_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLAMP |=> duty_q <= $past(out_max_q))
		else $error("PD duty above upper clamp");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> result_valid_q && state_q == ST_IDLE)
		else $error("result load lost");

endmodule
